[design/sspwm_pkg.sv]
`timescale 1ns / 1ps

package sspwm_pkg;

   localparam int MAX_BASES_DEF = 4096;
   localparam int WINDOW_LEN    = 10;
   localparam int BASE_W        = 2;
   localparam int SITE_W        = 14;
   localparam int SCORE_W       = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_STRAND_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SITE_KIND   = 1'd1;

   localparam logic [1:0] STRAND_FWD  = 2'd0;
   localparam logic [1:0] STRAND_REV  = 2'd1;
   localparam logic [1:0] STRAND_BOTH = 2'd2;

   localparam logic SITE_ACCEPTOR = 1'b0;
   localparam logic SITE_DONOR    = 1'b1;

   typedef logic [BASE_W-1:0]         base_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [SITE_W-1:0]  site_type;
   typedef score_type                 tab_type [WINDOW_LEN][4];

   localparam score_type ACC_MIN   = -16'sd1960;
   localparam score_type ACC_RANGE = 16'sd11918;
   localparam score_type DON_MIN   = -16'sd2259;
   localparam score_type DON_RANGE = 16'sd12417;

   localparam logic [SITE_W-1:0] ACC_OFFSET = 14'd4;
   localparam logic [SITE_W-1:0] DON_OFFSET = 14'd5;

   localparam tab_type DONOR_TAB = '{
      '{-16'sd92,   16'sd168,  -16'sd114,  16'sd103},
      '{ 16'sd132,  16'sd252,  -16'sd109, -16'sd138},
      '{-16'sd97,   16'sd273,  -16'sd167,  16'sd143},
      '{ 16'sd922, -16'sd208,  -16'sd132, -16'sd202},
      '{-16'sd107, -16'sd288,   16'sd1104, -16'sd225},
      '{-16'sd344, -16'sd344,   16'sd2406, -16'sd344},
      '{-16'sd344, -16'sd344,  -16'sd344,  16'sd2406},
      '{ 16'sd355, -16'sd236,   16'sd543, -16'sd223},
      '{ 16'sd939, -16'sd177,  -16'sd160, -16'sd207},
      '{ 16'sd222, -16'sd206,   16'sd1145, 16'sd185}
   };

   localparam tab_type ACCEPTOR_TAB = '{
      '{-16'sd201,  16'sd431,  -16'sd121,  16'sd350},
      '{ 16'sd115,  16'sd176,   16'sd199, -16'sd107},
      '{ 16'sd61,   16'sd838,  -16'sd191, -16'sd169},
      '{ 16'sd2548, -16'sd364, -16'sd364, -16'sd364},
      '{-16'sd364, -16'sd364,   16'sd2548, -16'sd364},
      '{ 16'sd704, -16'sd222,   16'sd347, -16'sd272},
      '{-16'sd142, -16'sd170,  -16'sd117,  16'sd1030},
      '{-16'sd167, -16'sd92,    16'sd974, -16'sd137},
      '{-16'sd33,   16'sd201,   16'sd157,  16'sd47},
      '{ 16'sd12,   16'sd485,  -16'sd91,   16'sd9}
   };

endpackage

[design/sspwm_if.sv]
`timescale 1ns / 1ps

interface sspwm_req_if import sspwm_pkg::*; ();
   logic     valid;
   logic     ready;
   base_type base;
   logic     last;

   modport source (output valid, output base, output last, input ready);
   modport sink (input valid, input base, input last, output ready);
endinterface

interface sspwm_rsp_if import sspwm_pkg::*; ();
   logic     valid;
   logic     ready;
   site_type forward_site;
   site_type reverse_site;
   logic     forward_valid;
   logic     reverse_valid;
   logic     too_long;

   modport source (output valid, output forward_site, output reverse_site,
                   output forward_valid, output reverse_valid, output too_long,
                   input ready);
   modport sink (input valid, input forward_site, input reverse_site,
                 input forward_valid, input reverse_valid, input too_long,
                 output ready);
endinterface

[design/splice_site_pwm_scanner_unit.sv]
`timescale 1ns / 1ps

// one base item accepted per cycle unless stalled; a last item passes stages 1, 2 and the result register
// pipeline: window shift and count, 10-term table sums, best compare and threshold check
// input stalls only when a last item meets a result still held at the output
// synchronous active-high reset clears the base count and overflow flag, the pipeline and the output;
// strand_mode resets to both strands and site_kind to acceptor
module splice_site_pwm_scanner_unit import sspwm_pkg::*; #(
   parameter int MAX_BASES = MAX_BASES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sspwm_req_if.sink             req_ch,
   sspwm_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BASES + 1);
   localparam int SUM_W = (CNT_W > SITE_W) ? CNT_W : SITE_W;
   localparam int THR_W = SCORE_W + 2;

   typedef base_type win_type [WINDOW_LEN];

   // configuration
   logic [1:0] strand_mode_ff;
   logic       site_kind_ff;

   // stretch state at the input
   win_type          window_ff;
   logic [CNT_W-1:0] count_ff;
   logic             ovf_ff;

   // stage 1
   logic             s1_valid_ff;
   logic             s1_last_ff;
   logic             s1_score_ff;
   logic             s1_ovf_ff;
   logic [CNT_W-1:0] s1_widx_ff;
   win_type          s1_win_ff;

   // stage 2
   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic             s2_score_ff;
   logic             s2_ovf_ff;
   logic [CNT_W-1:0] s2_widx_ff;
   score_type        s2_fs_ff;
   score_type        s2_rs_ff;

   // best so far
   score_type        best_f_ff;
   score_type        best_r_ff;
   logic [CNT_W-1:0] idx_f_ff;
   logic [CNT_W-1:0] idx_r_ff;

   // result register
   logic     rsp_valid_ff;
   site_type fwd_site_ff;
   site_type rev_site_ff;
   logic     fwd_valid_ff;
   logic     rev_valid_ff;
   logic     too_long_ff;

   logic             out_free;
   logic             adv;
   logic             acc;
   logic             ovf_now;
   win_type          win_in;
   logic [CNT_W-1:0] count_in;
   logic             score_in;
   logic [CNT_W-1:0] widx_in;
   score_type        fs_in;
   score_type        rs_in;
   logic             take_f;
   logic             take_r;
   score_type        best_f_in;
   score_type        best_r_in;
   logic [CNT_W-1:0] idx_f_in;
   logic [CNT_W-1:0] idx_r_in;
   logic             rep_f;
   logic             rep_r;
   logic [SITE_W-1:0] offset;
   score_type        f_min;
   score_type        f_rng;
   score_type        r_min;
   score_type        r_rng;
   logic [SUM_W-1:0] f_sum;
   logic [SUM_W-1:0] r_sum;
   site_type         fwd_site_in;
   site_type         rev_site_in;

   function automatic logic passes(score_type best, score_type mn, score_type rng);
      logic signed [THR_W-1:0] diff;
      diff = THR_W'(best) - THR_W'(mn);
      return (diff <<< 1) >= THR_W'(rng);
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign adv          = !(s2_valid_ff && s2_last_ff && !out_free);
   assign acc          = req_ch.valid && adv;
   assign req_ch.ready = adv;

   // window shift and base count
   always_comb begin
      ovf_now  = (count_ff == CNT_W'(MAX_BASES));
      win_in   = window_ff;
      count_in = count_ff;
      if (!ovf_now) begin
         for (int j = 0; j < WINDOW_LEN - 1; j++) begin
            win_in[j] = window_ff[j+1];
         end
         win_in[WINDOW_LEN-1] = req_ch.base;
         count_in = count_ff + CNT_W'(1);
      end
      score_in = !ovf_now && (count_ff >= CNT_W'(WINDOW_LEN - 1));
      widx_in  = count_ff - CNT_W'(WINDOW_LEN - 1);
   end

   // table sums over the window
   always_comb begin
      fs_in = '0;
      rs_in = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if (site_kind_ff == SITE_DONOR) begin
            fs_in = fs_in + DONOR_TAB[j][s1_win_ff[j]];
            rs_in = rs_in + ACCEPTOR_TAB[j][~s1_win_ff[WINDOW_LEN-1-j]];
         end else begin
            fs_in = fs_in + ACCEPTOR_TAB[j][s1_win_ff[j]];
            rs_in = rs_in + DONOR_TAB[j][~s1_win_ff[WINDOW_LEN-1-j]];
         end
      end
   end

   // best update and result forming
   always_comb begin
      take_f    = s2_score_ff && (s2_fs_ff > best_f_ff);
      take_r    = s2_score_ff && (s2_rs_ff > best_r_ff);
      best_f_in = take_f ? s2_fs_ff : best_f_ff;
      best_r_in = take_r ? s2_rs_ff : best_r_ff;
      idx_f_in  = take_f ? s2_widx_ff : idx_f_ff;
      idx_r_in  = take_r ? s2_widx_ff : idx_r_ff;

      rep_f = (strand_mode_ff == STRAND_FWD) || (strand_mode_ff == STRAND_BOTH);
      rep_r = (strand_mode_ff == STRAND_REV) || (strand_mode_ff == STRAND_BOTH);

      if (site_kind_ff == SITE_DONOR) begin
         offset = DON_OFFSET;
         f_min  = DON_MIN;
         f_rng  = DON_RANGE;
         r_min  = ACC_MIN;
         r_rng  = ACC_RANGE;
      end else begin
         offset = ACC_OFFSET;
         f_min  = ACC_MIN;
         f_rng  = ACC_RANGE;
         r_min  = DON_MIN;
         r_rng  = DON_RANGE;
      end

      f_sum = SUM_W'(idx_f_in) + SUM_W'(offset);
      r_sum = SUM_W'(idx_r_in) + SUM_W'(offset);
      fwd_site_in = (rep_f && passes(best_f_in, f_min, f_rng)) ? site_type'(f_sum[SITE_W-1:0])
                                                             : '1;
      rev_site_in = (rep_r && passes(best_r_in, r_min, r_rng)) ? site_type'(r_sum[SITE_W-1:0])
                                                             : '1;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strand_mode_ff <= STRAND_BOTH;
         site_kind_ff   <= SITE_ACCEPTOR;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STRAND_MODE: strand_mode_ff <= csr_wdata[1:0];
            REG_SITE_KIND:   site_kind_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         best_f_ff    <= '0;
         best_r_ff    <= '0;
         idx_f_ff     <= '0;
         idx_r_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            if (req_ch.last) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               count_ff <= count_in;
               ovf_ff   <= ovf_ff | ovf_now;
            end
         end
         if (adv) begin
            s1_valid_ff <= req_ch.valid;
            s2_valid_ff <= s1_valid_ff;
            if (s2_valid_ff) begin
               if (s2_last_ff) begin
                  best_f_ff <= '0;
                  best_r_ff <= '0;
                  idx_f_ff  <= '0;
                  idx_r_ff  <= '0;
               end else begin
                  best_f_ff <= best_f_in;
                  best_r_ff <= best_r_in;
                  idx_f_ff  <= idx_f_in;
                  idx_r_ff  <= idx_r_in;
               end
            end
         end
         if (adv && s2_valid_ff && s2_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (acc) begin
         window_ff   <= win_in;
         s1_win_ff   <= win_in;
         s1_last_ff  <= req_ch.last;
         s1_score_ff <= score_in;
         s1_ovf_ff   <= ovf_ff | ovf_now;
         s1_widx_ff  <= widx_in;
      end
      if (adv) begin
         s2_last_ff  <= s1_last_ff;
         s2_score_ff <= s1_valid_ff && s1_score_ff;
         s2_ovf_ff   <= s1_ovf_ff;
         s2_widx_ff  <= s1_widx_ff;
         s2_fs_ff    <= fs_in;
         s2_rs_ff    <= rs_in;
      end
      if (adv && s2_valid_ff && s2_last_ff) begin
         fwd_site_ff  <= fwd_site_in;
         rev_site_ff  <= rev_site_in;
         fwd_valid_ff <= rep_f;
         rev_valid_ff <= rep_r;
         too_long_ff  <= s2_ovf_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.forward_site  = fwd_site_ff;
   assign rsp_ch.reverse_site  = rev_site_ff;
   assign rsp_ch.forward_valid = fwd_valid_ff;
   assign rsp_ch.reverse_valid = rev_valid_ff;
   assign rsp_ch.too_long      = too_long_ff;

endmodule

[sim/splice_site_pwm_scanner_unit_tb.sv]
`timescale 1ns / 1ps

module splice_site_pwm_scanner_unit_tb import sspwm_pkg::*; ();

   localparam int MAX_LEN      = MAX_BASES_DEF;
   localparam int WIN          = 10;
   localparam int HOLD_CYCLES  = 200;
   localparam int QUIET_LIMIT  = 3000;
   localparam int ITEM_GOAL    = 1650;
   localparam int ACC_LO       = -1960;
   localparam int ACC_SPAN     = 11918;
   localparam int DON_LO       = -2259;
   localparam int DON_SPAN     = 12417;
   localparam int ACC_SHIFT    = 4;
   localparam int DON_SHIFT    = 5;
   localparam logic [1:0] STRAND_NONE = 2'd3;
   localparam logic [SITE_W-1:0] NO_SITE = '1;

   typedef logic [1:0] base_q_t[$];

   typedef struct packed {
      logic [SITE_W-1:0] fwd_site;
      logic [SITE_W-1:0] rev_site;
      logic              fwd_on;
      logic              rev_on;
      logic              over;
   } site_result_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sspwm_req_if req_ch ();
   sspwm_rsp_if rsp_ch ();

   splice_site_pwm_scanner_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   int acc_w [WIN][4] = '{
      '{-201, 431, -121, 350}, '{115, 176, 199, -107},
      '{61, 838, -191, -169}, '{2548, -364, -364, -364},
      '{-364, -364, 2548, -364}, '{704, -222, 347, -272},
      '{-142, -170, -117, 1030}, '{-167, -92, 974, -137},
      '{-33, 201, 157, 47}, '{12, 485, -91, 9}
   };

   int don_w [WIN][4] = '{
      '{-92, 168, -114, 103}, '{132, 252, -109, -138},
      '{-97, 273, -167, 143}, '{922, -208, -132, -202},
      '{-107, -288, 1104, -225}, '{-344, -344, 2406, -344},
      '{-344, -344, -344, 2406}, '{355, -236, 543, -223},
      '{939, -177, -160, -207}, '{222, -206, 1145, 185}
   };

   logic [1:0]   win_q [WIN];
   int           n_bases;
   int           best_f;
   int           best_r;
   int           idx_f;
   int           idx_r;
   logic         overflow;
   logic [1:0]   mode_r;
   logic         kind_r;
   site_result_t expected_sites[$];

   int errors;
   int idle_pct;
   int items_sent;
   int holds_asked;
   int holds_served;
   int hold_left;
   int quiet;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void clear_scan();
      foreach (win_q[k]) win_q[k] = 2'd0;
      n_bases  = 0;
      best_f   = 0;
      best_r   = 0;
      idx_f    = 0;
      idx_r    = 0;
      overflow = 1'b0;
   endfunction

   function automatic logic [SITE_W-1:0] site_of(input logic shown, input int best, idx, lo,
                                                 span, off);
      if (!shown || 2 * (best - lo) < span) return NO_SITE;
      return SITE_W'(idx + off);
   endfunction

   function automatic void scan_base(input logic [1:0] b, input logic l);
      int           fs;
      int           rs;
      int           off;
      logic         fwd_on;
      logic         rev_on;
      site_result_t res;
      if (n_bases >= MAX_LEN) begin
         overflow = 1'b1;
      end else begin
         for (int k = 0; k < WIN - 1; k++) win_q[k] = win_q[k + 1];
         win_q[WIN - 1] = b;
         n_bases++;
         if (n_bases >= WIN) begin
            fs = 0;
            rs = 0;
            for (int j = 0; j < WIN; j++) begin
               if (kind_r == SITE_DONOR) begin
                  fs += don_w[j][win_q[j]];
                  rs += acc_w[j][3 - int'(win_q[WIN - 1 - j])];
               end else begin
                  fs += acc_w[j][win_q[j]];
                  rs += don_w[j][3 - int'(win_q[WIN - 1 - j])];
               end
            end
            if (fs > best_f) begin
               best_f = fs;
               idx_f  = n_bases - WIN;
            end
            if (rs > best_r) begin
               best_r = rs;
               idx_r  = n_bases - WIN;
            end
         end
      end
      if (l) begin
         fwd_on = (mode_r == STRAND_FWD || mode_r == STRAND_BOTH);
         rev_on = (mode_r == STRAND_REV || mode_r == STRAND_BOTH);
         off    = (kind_r == SITE_DONOR) ? DON_SHIFT : ACC_SHIFT;
         res.fwd_site = (kind_r == SITE_DONOR) ?
                        site_of(fwd_on, best_f, idx_f, DON_LO, DON_SPAN, off) :
                        site_of(fwd_on, best_f, idx_f, ACC_LO, ACC_SPAN, off);
         res.rev_site = (kind_r == SITE_DONOR) ?
                        site_of(rev_on, best_r, idx_r, ACC_LO, ACC_SPAN, off) :
                        site_of(rev_on, best_r, idx_r, DON_LO, DON_SPAN, off);
         res.fwd_on   = fwd_on;
         res.rev_on   = rev_on;
         res.over     = overflow;
         expected_sites.push_back(res);
         clear_scan();
      end
   endfunction

   task automatic check_field(input string name, input logic [SITE_W-1:0] want, got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, $signed(want),
                     $signed(got));
      end
   endtask

   task automatic check_result();
      site_result_t want;
      site_result_t got;
      got = {rsp_ch.forward_site, rsp_ch.reverse_site, rsp_ch.forward_valid,
             rsp_ch.reverse_valid, rsp_ch.too_long};
      if (expected_sites.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("result with no item pending: fwd %0d rev %0d",
                     $signed(got.fwd_site), $signed(got.rev_site));
      end else begin
         want = expected_sites.pop_front();
         check_field("forward_site", want.fwd_site, got.fwd_site);
         check_field("reverse_site", want.rev_site, got.rev_site);
         check_field("forward_valid", SITE_W'(want.fwd_on), SITE_W'(got.fwd_on));
         check_field("reverse_valid", SITE_W'(want.rev_on), SITE_W'(got.rev_on));
         check_field("too_long", SITE_W'(want.over), SITE_W'(got.over));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         mode_r = STRAND_BOTH;
         kind_r = SITE_ACCEPTOR;
         expected_sites.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_result();
         if (csr_we) begin
            if (csr_index == REG_STRAND_MODE) mode_r = csr_wdata;
            else kind_r = csr_wdata[0];
         end
         if (req_ch.valid && req_ch.ready) scan_base(req_ch.base, req_ch.last);
      end
   end

   // result side: random stalls plus long hold-offs on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
   end

   initial begin
      wait (quiet >= QUIET_LIMIT);
      $display("splice_site_pwm_scanner_unit regression: fail");
      $finish;
   end

   function automatic base_q_t motif(input logic donor, input logic rev);
      base_q_t q;
      int      row;
      int      pick;
      int      top;
      int      w;
      for (int j = 0; j < WIN; j++) begin
         row  = rev ? WIN - 1 - j : j;
         pick = 0;
         top  = -100000;
         for (int c = 0; c < 4; c++) begin
            w = donor ? don_w[row][c] : acc_w[row][c];
            if (w > top) begin
               top  = w;
               pick = c;
            end
         end
         q.push_back(rev ? 2'(3 - pick) : 2'(pick));
      end
      return q;
   endfunction

   function automatic base_q_t make_stretch(input int len, input bit planted);
      base_q_t q;
      base_q_t m;
      int      pos;
      for (int k = 0; k < len; k++) q.push_back(2'($urandom_range(3)));
      if (planted && len >= WIN) begin
         m   = motif(1'($urandom_range(1)), 1'($urandom_range(1)));
         pos = $urandom_range(len - WIN);
         for (int k = 0; k < WIN; k++) q[pos + k] = m[k];
         repeat ($urandom_range(2)) q[pos + $urandom_range(WIN - 1)] = 2'($urandom_range(3));
      end
      return q;
   endfunction

   task automatic send_base(input logic [1:0] b, input logic l);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.base  <= b;
      req_ch.last  <= l;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic feed_stretch(input base_q_t q, input bit closes);
      foreach (q[k]) send_base(q[k], closes && (k == q.size() - 1));
   endtask

   task automatic wait_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_sites.size() != 0) @(posedge clock);
   endtask

   // a stretch may still be in the pipe with no result behind it
   task automatic settle();
      wait_results();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_short_stretches();
      base_q_t q;
      q = {2'd0};
      feed_stretch(q, 1'b1);
      q = {};
      repeat (WIN - 1) q.push_back(2'd3);
      feed_stretch(q, 1'b1);
   endtask

   task automatic test_consensus();
      feed_stretch(motif(SITE_ACCEPTOR, 1'b0), 1'b1);
      feed_stretch(motif(SITE_DONOR, 1'b1), 1'b1);
   endtask

   task automatic test_kind_switch();
      base_q_t q;
      base_q_t head;
      base_q_t tail;
      q    = motif(SITE_DONOR, 1'b0);
      head = q[0:4];
      tail = q[5:WIN-1];
      feed_stretch(head, 1'b0);
      settle();
      write_csr(REG_SITE_KIND, {1'b0, SITE_DONOR});
      feed_stretch(tail, 1'b1);
      settle();
      write_csr(REG_SITE_KIND, {1'b0, SITE_ACCEPTOR});
   endtask

   task automatic test_no_strand();
      base_q_t q;
      q = {2'd1};
      settle();
      write_csr(REG_STRAND_MODE, STRAND_NONE);
      feed_stretch(q, 1'b1);
      feed_stretch(motif(SITE_ACCEPTOR, 1'b0), 1'b1);
      settle();
      write_csr(REG_STRAND_MODE, STRAND_BOTH);
   endtask

   task automatic test_overflow();
      base_q_t q;
      base_q_t m;
      settle();
      write_csr(REG_SITE_KIND, {1'b0, SITE_DONOR});
      idle_pct = 0;
      q = make_stretch(MAX_LEN + 6, 1'b0);
      m = motif(SITE_DONOR, 1'b0);
      for (int k = 0; k < WIN; k++) q[MAX_LEN - WIN + k] = m[k];
      feed_stretch(q, 1'b1);
      idle_pct = 16;
      settle();
      write_csr(REG_SITE_KIND, {1'b0, SITE_ACCEPTOR});
   endtask

   task automatic test_backpressure();
      holds_asked <= holds_asked + 1;
      idle_pct = 0;
      repeat (30) feed_stretch(make_stretch($urandom_range(1, 3), 1'b0), 1'b1);
      idle_pct = 16;
      wait_results();
   endtask

   task automatic test_sender_pause();
      repeat (5) begin
         feed_stretch(make_stretch($urandom_range(WIN, 40), 1'b1), 1'b1);
         wait_results();
      end
   endtask

   task automatic test_random_stretches();
      int      start;
      int      done;
      int      lot;
      base_q_t q;
      start = items_sent;
      while (items_sent - start < ITEM_GOAL) begin
         done     = items_sent - start;
         idle_pct = (done > ITEM_GOAL * 2 / 5 && done < ITEM_GOAL * 3 / 5) ? 0 : 16;
         lot      = $urandom_range(99);
         if (lot < 12) begin
            settle();
            write_csr(REG_STRAND_MODE, 2'($urandom_range(3)));
            write_csr(REG_SITE_KIND, 2'($urandom_range(3)));
         end
         lot = $urandom_range(99);
         if (lot < 10) q = make_stretch($urandom_range(1, WIN - 1), 1'b0);
         else if (lot < 15) q = make_stretch($urandom_range(WIN, 60), 1'b0);
         else if (lot < 18) q = make_stretch($urandom_range(100, 250), 1'b1);
         else q = make_stretch($urandom_range(WIN, 40), 1'b1);
         feed_stretch(q, 1'b1);
      end
      idle_pct = 16;
   endtask

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.base  <= '0;
      req_ch.last  <= 1'b0;
      idle_pct = 16;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_stretches();
      test_consensus();
      test_kind_switch();
      test_no_strand();
      test_overflow();
      test_backpressure();
      test_sender_pause();
      test_random_stretches();
      wait_results();
      repeat (8) @(posedge clock);
      if (errors == 0 && expected_sites.size() == 0)
         $display("splice_site_pwm_scanner_unit regression: pass");
      else
         $display("splice_site_pwm_scanner_unit regression: fail");
      $finish;
   end

endmodule
